FILE: hdl/bfsrs_pkg.sv
// Shared definitions for the bit field rank/select block: field widths,
// operation codes and the packed request/result layouts of the stream ports.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package bfsrs_pkg;

  // Size of the bit field in the default build (power of two).
  localparam int unsigned FIELD_BITS_DEF = 1024;

  // Fixed field widths of the stream payloads.
  localparam int unsigned OP_W     = 3;
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned HANDLE_W = 11;
  localparam int unsigned ANSWER_W = 11;
  localparam int unsigned TOTAL_W  = 11;

  localparam int unsigned REQ_W     = INDEX_W + 1 + HANDLE_W;
  localparam int unsigned S_TDATA_W = ((REQ_W + 7) / 8) * 8;
  localparam int unsigned RES_W     = ANSWER_W + TOTAL_W;
  localparam int unsigned M_TDATA_W = ((RES_W + 7) / 8) * 8;

  // Operation codes carried on tuser.
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
  localparam logic [OP_W-1:0] OP_SET    = 3'd1;
  localparam logic [OP_W-1:0] OP_READ   = 3'd2;
  localparam logic [OP_W-1:0] OP_RANK   = 3'd3;
  localparam logic [OP_W-1:0] OP_SELECT = 3'd4;
  localparam logic [OP_W-1:0] OP_TOTAL  = 3'd5;

  // Request fields, last field in the lowest bits.
  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic                bit_value;
    logic [INDEX_W-1:0]  bit_index;
  } req_t;

  // Result fields, last field in the lowest bits.
  typedef struct packed {
    logic [TOTAL_W-1:0]  total_ones;
    logic [ANSWER_W-1:0] answer;
  } res_t;

endpackage

`default_nettype wire

FILE: hdl/bitfield_sum_tree_rank_select.sv
// Top level of the bit field rank/select block: stream ports, the sequencer,
// the shared add/subtract unit and the leaf and node count memories.
// Depends on bfsrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Keeps a FIELD_BITS-wide bit field (power of two) with a complete binary tree
// of ones-counts above it, stored in heap order in a node count memory beside a
// one-bit leaf memory. A request carries an operation on tuser: clear all, set a
// bit, read a bit, rank (ones strictly before an index), select (index of the
// one with a given ordinal) or total. Each request gives exactly one result
// with the answer and the number of ones after the request. The block works on
// one request at a time and drops tready from acceptance until its result is
// loaded into the output register; a result that waits there does not stop the
// next request from being taken. Set checks the leaf, then steps one tree level
// per cycle back to the root; rank and select take one level per cycle, paced
// by the registered memory read feeding the shared adder; read bit reads its
// leaf and total uses the stored count, and every request ends by loading the
// output register. Clear sweeps both memories one address per cycle, and after
// reset the same sweep runs before the first request is taken. Set keeps the
// tree current by adding or subtracting one along the path to the root when the
// bit changes. Index bits above the field size are ignored; answers and counts
// are reported in their low 11 bits.
module bitfield_sum_tree_rank_select #(
  parameter int unsigned FIELD_BITS = bfsrs_pkg::FIELD_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_axis_tvalid,
  output      logic                           s_axis_tready,
  // bit_index [9:0], bit_value [10], handle [21:11], zero pad [23:22]
  input  wire logic [bfsrs_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // operation [2:0]
  input  wire logic [bfsrs_pkg::OP_W-1:0]      s_axis_tuser,
  output      logic                           m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // answer [10:0], total_ones [21:11], zero pad [23:22]
  output      logic [bfsrs_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import bfsrs_pkg::*;

  // Index, count and working widths follow the field size.
  localparam int unsigned IW = $clog2(FIELD_BITS);
  localparam int unsigned CW = IW + 1;
  localparam int unsigned HW = (CW > HANDLE_W) ? CW : HANDLE_W;

  localparam logic [IW:0] ONE_H = (IW + 1)'(1);
  localparam logic [IW:0] TWO_H = (IW + 1)'(2);

  // Sequencer states.
  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_SET_CHK  = 3'd2;
  localparam logic [2:0] S_SET_WALK = 3'd3;
  localparam logic [2:0] S_RANK     = 3'd4;
  localparam logic [2:0] S_SEL      = 3'd5;
  localparam logic [2:0] S_READ     = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  // Storage: leaves and heap-ordered node counts (entry 0 unused).
  logic          leaf_mem [FIELD_BITS];
  logic [CW-1:0] node_mem [FIELD_BITS];

  // Control registers.
  logic [2:0]    state, state_next;
  logic [IW-1:0] sweep, sweep_next;
  logic          clear_reply, clear_reply_next;
  logic [CW-1:0] total, total_next;

  // Working registers.
  logic [IW:0]   heap, heap_next;
  logic [HW-1:0] acc, acc_next;
  logic          set_val, set_val_next;
  res_t          out_res;

  // Memory ports.
  logic [IW:0]   rd_heap;
  logic          rd_leaf;
  logic          leaf_q;
  logic [CW-1:0] node_q;
  logic [CW-1:0] count_rd;
  logic          leaf_we, leaf_wd;
  logic [IW-1:0] leaf_wa;
  logic          node_we;
  logic [IW-1:0] node_wa;
  logic [CW-1:0] node_wd;

  // Shared add/subtract unit.
  logic [HW-1:0] unit_a, unit_b;
  logic          unit_sub;
  logic [HW:0]   unit_res;

  req_t          req;
  logic [IW-1:0] req_idx;
  logic          sel_go;
  logic [IW:0]   sel_heap;
  logic          out_load;
  logic [HW-1:0] total_ext;

  assign req      = req_t'(s_axis_tdata[REQ_W-1:0]);
  assign req_idx  = IW'(req.bit_index);
  assign count_rd = rd_leaf ? CW'(leaf_q) : node_q;

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tdata  = M_TDATA_W'(out_res);
  assign total_ext     = HW'(total);

  // Select goes right when the handle is not below the left count (no borrow).
  assign sel_go   = ~unit_res[HW];
  assign sel_heap = {heap[IW-1:0], sel_go};

  // Operand selection for the one adder.
  always_comb begin
    unit_a   = acc;
    unit_b   = '0;
    unit_sub = 1'b0;
    unique case (state)
      S_SET_WALK: begin
        unit_a   = HW'(count_rd);
        unit_b   = HW'(1);
        unit_sub = ~set_val;
      end
      S_RANK: begin
        unit_b = heap[0] ? HW'(count_rd) : '0;
      end
      S_SEL: begin
        unit_b   = HW'(count_rd);
        unit_sub = 1'b1;
      end
      default: begin
        unit_b = '0;
      end
    endcase
  end

  assign unit_res = unit_sub ? ({1'b0, unit_a} - {1'b0, unit_b})
                             : ({1'b0, unit_a} + {1'b0, unit_b});

  // Sequencer.
  always_comb begin
    state_next       = state;
    sweep_next       = sweep;
    clear_reply_next = clear_reply;
    total_next       = total;
    heap_next        = heap;
    acc_next         = acc;
    set_val_next     = set_val;
    rd_heap          = '0;
    leaf_we          = 1'b0;
    leaf_wa          = heap[IW-1:0];
    leaf_wd          = set_val;
    node_we          = 1'b0;
    node_wa          = heap[IW-1:0];
    node_wd          = unit_res[CW-1:0];
    out_load         = 1'b0;

    unique case (state)
      S_CLEAR: begin
        // Zero one leaf and one node per cycle.
        leaf_we    = 1'b1;
        leaf_wa    = sweep;
        leaf_wd    = 1'b0;
        node_we    = 1'b1;
        node_wa    = sweep;
        node_wd    = '0;
        sweep_next = sweep + IW'(1);
        total_next = '0;
        if (&sweep) begin
          acc_next   = '0;
          state_next = clear_reply ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          unique case (s_axis_tuser)
            OP_CLEAR: begin
              sweep_next       = '0;
              clear_reply_next = 1'b1;
              state_next       = S_CLEAR;
            end
            OP_SET: begin
              heap_next    = {1'b1, req_idx};
              rd_heap      = {1'b1, req_idx};
              set_val_next = req.bit_value;
              state_next   = S_SET_CHK;
            end
            OP_READ: begin
              rd_heap    = {1'b1, req_idx};
              state_next = S_READ;
            end
            OP_RANK: begin
              // Fetch the left sibling; it only counts when the walk is a right child.
              heap_next  = {1'b1, req_idx};
              rd_heap    = {1'b1, req_idx} & ~ONE_H;
              acc_next   = '0;
              state_next = S_RANK;
            end
            OP_SELECT: begin
              heap_next  = ONE_H;
              rd_heap    = TWO_H;
              acc_next   = HW'(req.handle);
              state_next = S_SEL;
            end
            OP_TOTAL: begin
              acc_next   = total_ext;
              state_next = S_DONE;
            end
            default: begin
              acc_next   = '0;
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_SET_CHK: begin
        acc_next = '0;
        if (count_rd[0] == set_val) begin
          // Bit unchanged: the tree stays as it is.
          state_next = S_DONE;
        end else begin
          leaf_we    = 1'b1;
          heap_next  = heap >> 1;
          rd_heap    = heap >> 1;
          state_next = S_SET_WALK;
        end
      end
      S_SET_WALK: begin
        // Step the count on the path by one and advance toward the root.
        node_we = 1'b1;
        if (heap == ONE_H) begin
          total_next = unit_res[CW-1:0];
          state_next = S_DONE;
        end else begin
          heap_next = heap >> 1;
          rd_heap   = heap >> 1;
        end
      end
      S_RANK: begin
        acc_next = unit_res[HW-1:0];
        if ((heap >> 1) == ONE_H) begin
          state_next = S_DONE;
        end else begin
          heap_next = heap >> 1;
          rd_heap   = (heap >> 1) & ~ONE_H;
        end
      end
      S_SEL: begin
        if (sel_go) begin
          acc_next = unit_res[HW-1:0];
        end
        if (sel_heap[IW]) begin
          // Reached a leaf: answer its index.
          acc_next   = HW'(sel_heap[IW-1:0]);
          state_next = S_DONE;
        end else begin
          heap_next = sel_heap;
          rd_heap   = {sel_heap[IW-1:0], 1'b0};
        end
      end
      S_READ: begin
        acc_next   = HW'(count_rd);
        state_next = S_DONE;
      end
      S_DONE: begin
        // Hold the result until the output register is free.
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load         = 1'b1;
          clear_reply_next = 1'b0;
          state_next       = S_IDLE;
        end
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      sweep         <= '0;
      clear_reply   <= 1'b0;
      total         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state       <= state_next;
      sweep       <= sweep_next;
      clear_reply <= clear_reply_next;
      total       <= total_next;
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    heap    <= heap_next;
    acc     <= acc_next;
    set_val <= set_val_next;
    if (out_load) begin
      out_res.answer     <= acc[ANSWER_W-1:0];
      out_res.total_ones <= total_ext[TOTAL_W-1:0];
    end
  end

  // Memory write ports.
  always_ff @(posedge clk) begin
    if (leaf_we) begin
      leaf_mem[leaf_wa] <= leaf_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_wa] <= node_wd;
    end
  end

  // Registered read of one heap entry; the top bit picks leaf or node.
  always_ff @(posedge clk) begin
    leaf_q  <= leaf_mem[rd_heap[IW-1:0]];
    node_q  <= node_mem[rd_heap[IW-1:0]];
    rd_leaf <= rd_heap[IW];
  end

endmodule

`default_nettype wire

FILE: hdl/bfsrs_checker.sv
// Port-level checks for the bit field rank/select block, bound to its top level.
// Depends on bfsrs_pkg and bitfield_sum_tree_rank_select.
`timescale 1ns / 1ps
`default_nettype none

module bfsrs_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           s_axis_tvalid,
  input wire logic                           s_axis_tready,
  input wire logic [bfsrs_pkg::OP_W-1:0]      s_axis_tuser,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [bfsrs_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import bfsrs_pkg::*;

  logic [OP_W-1:0] last_op;
  res_t            res;

  assign res = res_t'(m_axis_tdata[RES_W-1:0]);

  // Track the operation of the request in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_op <= OP_CLEAR;
    end else if (s_axis_tvalid && s_axis_tready) begin
      last_op <= s_axis_tuser;
    end
  end

  // One request at a time: tready drops after an accept.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while another is in flight");

  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (!$past(m_axis_tvalid) || $past(m_axis_tready)) && last_op == OP_CLEAR
    |-> res.answer == '0 && res.total_ones == '0)
    else $error("clear result not zero");

  a_set_result: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (!$past(m_axis_tvalid) || $past(m_axis_tready)) && last_op == OP_SET
    |-> res.answer == '0)
    else $error("set result answer not zero");

  a_read_result: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (!$past(m_axis_tvalid) || $past(m_axis_tready)) && last_op == OP_READ
    |-> res.answer[ANSWER_W-1:1] == '0)
    else $error("read bit answer wider than one bit");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind bitfield_sum_tree_rank_select bfsrs_checker u_bfsrs_checker (.*);

`default_nettype wire
